>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the velocity unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define PIV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("piv: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define PIV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("piv: next-cycle check failed");

// Next-cycle implication that stays armed through reset.
`define PIV_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("piv: reset check failed");

`endif

>>> sv/piv_pkg.sv
// Shared constants and codes of the particle implosion velocity unit.
`default_nettype none
package piv_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ATTRACT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRACT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRACT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULL_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REACH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_REACH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KILL_EN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PULL_MODE  = 3'd7;

    localparam logic [1:0] MODE_UNIT_ADD = 2'd0;
    localparam logic [1:0] MODE_UNIT_SET = 2'd1;
    localparam logic [1:0] MODE_PROP     = 2'd2;

    typedef logic [1:0] t_cls;
    localparam t_cls CLS_PASS = 2'd0;
    localparam t_cls CLS_KILL = 2'd1;
    localparam t_cls CLS_UNIT = 2'd2;
    localparam t_cls CLS_PROP = 2'd3;
endpackage
`default_nettype wire

>>> sv/piv_queue.sv
// Small register queue used between front and back and at the result side.
`default_nettype none
module piv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = piv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

>>> sv/piv_front.sv
// Front part: offsets, squared distance, proportional pull and classification.
`default_nettype none
module piv_front #(
    parameter int W = piv_pkg::COORD_WIDTH_DEF,
    parameter int F = piv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_vld,
    output logic                      o_in_rdy,
    input  wire logic [2:0][W-1:0]    i_pos,
    input  wire logic [2:0][W-1:0]    i_vel,
    input  wire logic [2:0][W-1:0]    i_attract,
    input  wire logic [W-1:0]         i_scale,
    input  wire logic [W-2:0]         i_max_reach,
    input  wire logic [W-2:0]         i_min_reach,
    input  wire logic                 i_kill_en,
    input  wire logic [1:0]           i_mode,
    output logic                      o_mid_vld,
    input  wire logic                 i_mid_rdy,
    output logic [11*W+6:0]           o_mid_data
);
    localparam int SW = 2 * W + 2;
    localparam int PW = 2 * W + 1;
    localparam logic signed [PW:0] SMAX = {{(PW + 2 - W){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [PW:0] SMIN = ~SMAX;

    typedef struct packed {
        piv_pkg::t_cls           cls;
        logic [2:0][W-1:0]       res;
        logic [2:0][2*W-1:0]     num;
        logic [2:0]              neg;
        logic [SW-1:0]           s;
    } t_mid;

    function automatic logic [W-1:0] sat_w(input logic signed [PW:0] x);
        logic [W-1:0] y;
        if (x > SMAX) begin
            y = {1'b0, {(W - 1){1'b1}}};
        end else if (x < SMIN) begin
            y = {1'b1, {(W - 1){1'b0}}};
        end else begin
            y = x[W-1:0];
        end
        return y;
    endfunction

    logic                 fe;
    logic                 r_vld0, r_vld1, r_vld2, r_vld3;
    logic signed [W:0]    r0_d [3];
    logic signed [W-1:0]  r0_v [3];
    logic [2*W-1:0]       r1_sq [3];
    logic signed [PW-1:0] r1_p [3];
    logic signed [W-1:0]  r1_v [3];
    logic [2*W-3:0]       r_max_sq, r_min_sq;
    logic [SW-1:0]        r2_s;
    logic [2:0][2*W-1:0]  r2_num;
    logic [2:0]           r2_neg;
    logic [2:0][W-1:0]    r2_prop, r2_v;
    t_mid                 r3;
    t_mid                 n3;
    logic [W-1:0]         n1_mag [3];

    // Stall the whole front when its last stage cannot hand off.
    assign fe         = !(r_vld3 && !i_mid_rdy);
    assign o_in_rdy   = fe;
    assign o_mid_vld  = r_vld3;
    assign o_mid_data = r3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (fe) begin
            r_vld0 <= i_in_vld;
            r_vld1 <= r_vld0;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // Reach limits squared; settle long before an item needs them.
    always_ff @(posedge i_clk) begin
        r_max_sq <= i_max_reach * i_max_reach;
        r_min_sq <= i_min_reach * i_min_reach;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_mag[k] = r0_d[k][W] ? W'(-r0_d[k]) : W'(r0_d[k]);
        end
    end

    always_comb begin
        logic gt, lt, zero;
        gt   = r2_s > SW'(r_max_sq);
        lt   = i_kill_en && (r2_s < SW'(r_min_sq));
        zero = (r2_s == '0);
        n3.s   = r2_s;
        n3.num = r2_num;
        n3.neg = r2_neg;
        if (gt) begin
            n3.cls = piv_pkg::CLS_PASS;
        end else if (lt) begin
            n3.cls = piv_pkg::CLS_KILL;
        end else if (zero) begin
            n3.cls = piv_pkg::CLS_PASS;
        end else if (i_mode == piv_pkg::MODE_UNIT_ADD || i_mode == piv_pkg::MODE_UNIT_SET) begin
            n3.cls = piv_pkg::CLS_UNIT;
        end else if (i_mode == piv_pkg::MODE_PROP) begin
            n3.cls = piv_pkg::CLS_PROP;
        end else begin
            n3.cls = piv_pkg::CLS_PASS;
        end
        n3.res = (n3.cls == piv_pkg::CLS_PROP) ? r2_prop : r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            for (int k = 0; k < 3; k++) begin
                r0_d[k] <= $signed({i_attract[k][W-1], i_attract[k]})
                         - $signed({i_pos[k][W-1], i_pos[k]});
                r0_v[k] <= $signed(i_vel[k]);
                r1_sq[k] <= n1_mag[k] * n1_mag[k];
                r1_p[k]  <= $signed(i_scale) * r0_d[k];
                r1_v[k]  <= r0_v[k];
                r2_num[k] <= r1_p[k][PW-1] ? (2*W)'(-r1_p[k]) : (2*W)'(r1_p[k]);
                r2_neg[k] <= r1_p[k][PW-1] ^ 1'b0;
                r2_prop[k] <= sat_w((PW + 1)'(r1_p[k] >>> F) + (PW + 1)'(r1_v[k]));
                r2_v[k]    <= r1_v[k];
            end
            r2_s <= SW'(r1_sq[0]) + SW'(r1_sq[1]) + SW'(r1_sq[2]);
            r3   <= n3;
        end
    end
endmodule
`default_nettype wire

>>> sv/piv_back.sv
// Back part: pipelined square root, three pipelined dividers, final add and clamp.
`default_nettype none
module piv_back #(
    parameter int W = piv_pkg::COORD_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_mid_vld,
    output logic                  o_mid_pop,
    input  wire logic [11*W+6:0]  i_mid_data,
    input  wire logic [1:0]       i_mode,
    output logic                  o_out_vld,
    input  wire logic             i_out_rdy,
    output logic [3*W:0]          o_out_data
);
    localparam int SW = 2 * W + 2;
    localparam int RB = W + 1;
    localparam int DW = 2 * W + 1;
    localparam int NS = RB + W;
    localparam logic signed [W+1:0] SMAX = {3'b000, {(W - 1){1'b1}}};
    localparam logic signed [W+1:0] SMIN = ~SMAX;

    typedef struct packed {
        piv_pkg::t_cls           cls;
        logic [2:0][W-1:0]       res;
        logic [2:0][2*W-1:0]     num;
        logic [2:0]              neg;
        logic [SW-1:0]           s;
    } t_mid;

    typedef struct packed {
        piv_pkg::t_cls           cls;
        logic [2:0][W-1:0]       res;
        logic [2:0][2*W-1:0]     num;
        logic [2:0]              neg;
        logic [SW-1:0]           rem;
        logic [RB-1:0]           root;
        logic [2:0][W-1:0]       quot;
    } t_bk;

    t_mid            mid;
    t_bk             init;
    t_bk             a_st [NS];
    t_bk             n_st [NS];
    t_bk             r_st [NS];
    logic [NS-1:0]   r_vld;
    logic            adv;
    t_bk             fin;
    logic [2:0][W-1:0] fin_vel;

    assign mid       = i_mid_data;
    assign adv       = i_out_rdy || !r_vld[NS-1];
    assign o_mid_pop = adv && i_mid_vld;
    assign o_out_vld = r_vld[NS-1];

    always_comb begin
        init.cls  = mid.cls;
        init.res  = mid.res;
        init.num  = mid.num;
        init.neg  = mid.neg;
        init.rem  = mid.s;
        init.root = '0;
        init.quot = '0;
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign a_st[k] = init;
        end else begin : g_next
            assign a_st[k] = r_st[k-1];
        end

        if (k < RB) begin : g_sqrt
            localparam int I = RB - 1 - k;
            logic [SW-1:0] trial;
            always_comb begin
                trial = (SW'(a_st[k].root) << (I + 1)) | (SW'(1) << (2 * I));
                n_st[k] = a_st[k];
                if (a_st[k].rem >= trial) begin
                    n_st[k].rem     = a_st[k].rem - trial;
                    n_st[k].root[I] = 1'b1;
                end
            end
        end else begin : g_div
            localparam int I = W - 1 - (k - RB);
            logic [DW-1:0] dv;
            always_comb begin
                dv = DW'(a_st[k].root) << I;
                n_st[k] = a_st[k];
                for (int j = 0; j < 3; j++) begin
                    if (DW'(a_st[k].num[j]) >= dv) begin
                        n_st[k].num[j]     = a_st[k].num[j] - dv[2*W-1:0];
                        n_st[k].quot[j][I] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], o_mid_pop};
        end
    end

    assign fin = r_st[NS-1];

    always_comb begin
        logic signed [W:0]   t;
        logic signed [W+1:0] sum;
        for (int j = 0; j < 3; j++) begin
            t = fin.neg[j] ? -$signed({1'b0, fin.quot[j]}) : $signed({1'b0, fin.quot[j]});
            if (i_mode == piv_pkg::MODE_UNIT_ADD) begin
                sum = (W + 2)'($signed(fin.res[j])) + (W + 2)'(t);
            end else begin
                sum = (W + 2)'(t);
            end
            if (fin.cls != piv_pkg::CLS_UNIT) begin
                fin_vel[j] = fin.res[j];
            end else if (sum > SMAX) begin
                fin_vel[j] = {1'b0, {(W - 1){1'b1}}};
            end else if (sum < SMIN) begin
                fin_vel[j] = {1'b1, {(W - 1){1'b0}}};
            end else begin
                fin_vel[j] = sum[W-1:0];
            end
        end
    end

    assign o_out_data = {(fin.cls == piv_pkg::CLS_KILL), fin_vel};
endmodule
`default_nettype wire

>>> sv/particle_implosion_velocity_unit.sv
// Top level of the particle implosion velocity unit.
//
//   channel   direction  handshake             payload
//   input     in         push / full           i_pos_x..z, i_vel_x..z
//   result    out        empty / pop           o_new_vel_x..z, o_kill
//   config    in         i_cfg_valid / ready   i_cfg_index, i_cfg_data
//
// One beat is taken per cycle and one result leaves per cycle in steady state,
// unless a full queue stalls the pipelines. Each beat passes the square root pipeline
// (COORD_WIDTH+1 stages) and then the divide pipeline (COORD_WIDTH stages).
// Reset is synchronous, active low; it clears both queues and all stage valids.
// A full result queue freezes the back pipeline; the middle queue then fills
// and the front holds, raising full.
`default_nettype none
module particle_implosion_velocity_unit #(
    parameter int COORD_WIDTH = piv_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = piv_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = piv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [COORD_WIDTH-1:0]        i_pos_x,
    input  wire logic [COORD_WIDTH-1:0]        i_pos_y,
    input  wire logic [COORD_WIDTH-1:0]        i_pos_z,
    input  wire logic [COORD_WIDTH-1:0]        i_vel_x,
    input  wire logic [COORD_WIDTH-1:0]        i_vel_y,
    input  wire logic [COORD_WIDTH-1:0]        i_vel_z,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [COORD_WIDTH-1:0]             o_new_vel_x,
    output logic [COORD_WIDTH-1:0]             o_new_vel_y,
    output logic [COORD_WIDTH-1:0]             o_new_vel_z,
    output logic                               o_kill,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [piv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]        i_cfg_data
);
    localparam int W  = COORD_WIDTH;
    localparam int MW = 11 * W + 7;
    localparam int OW = 3 * W + 1;

    logic [2:0][W-1:0] r_attract;
    logic [W-1:0]      r_scale;
    logic [W-2:0]      r_max_reach, r_min_reach;
    logic              r_kill_en;
    logic [1:0]        r_mode;

    logic              in_rdy;
    logic              mid_push, mid_full, mid_empty, mid_pop;
    logic [MW-1:0]     mid_wdata, mid_rdata;
    logic              out_push, out_full;
    logic [OW-1:0]     out_wdata, out_rdata;

    // Registers are always ready; a write takes effect in the following cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attract   <= '0;
            r_scale     <= '0;
            r_max_reach <= '0;
            r_min_reach <= '0;
            r_kill_en   <= 1'b0;
            r_mode      <= piv_pkg::MODE_UNIT_ADD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                piv_pkg::REG_ATTRACT_X:  r_attract[0] <= i_cfg_data;
                piv_pkg::REG_ATTRACT_Y:  r_attract[1] <= i_cfg_data;
                piv_pkg::REG_ATTRACT_Z:  r_attract[2] <= i_cfg_data;
                piv_pkg::REG_PULL_SCALE: r_scale      <= i_cfg_data;
                piv_pkg::REG_MAX_REACH:  r_max_reach  <= i_cfg_data[W-2:0];
                piv_pkg::REG_MIN_REACH:  r_min_reach  <= i_cfg_data[W-2:0];
                piv_pkg::REG_KILL_EN:    r_kill_en    <= i_cfg_data[0];
                piv_pkg::REG_PULL_MODE:  r_mode       <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign full = !in_rdy;

    // Front: offsets, distance squared, proportional pull, classification.
    piv_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (push),
        .o_in_rdy    (in_rdy),
        .i_pos       ({i_pos_z, i_pos_y, i_pos_x}),
        .i_vel       ({i_vel_z, i_vel_y, i_vel_x}),
        .i_attract   (r_attract),
        .i_scale     (r_scale),
        .i_max_reach (r_max_reach),
        .i_min_reach (r_min_reach),
        .i_kill_en   (r_kill_en),
        .i_mode      (r_mode),
        .o_mid_vld   (mid_push),
        .i_mid_rdy   (!mid_full),
        .o_mid_data  (mid_wdata)
    );

    // Decouple front from back so each stalls on its own.
    piv_queue #(
        .WIDTH (MW),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    // Back: root, divide, final add and clamp.
    piv_back #(
        .W (W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mid_vld  (!mid_empty),
        .o_mid_pop  (mid_pop),
        .i_mid_data (mid_rdata),
        .i_mode     (r_mode),
        .o_out_vld  (out_push),
        .i_out_rdy  (!out_full),
        .o_out_data (out_wdata)
    );

    // Result queue: hold finished beats until popped.
    piv_queue #(
        .WIDTH (OW),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_wdata),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    assign o_new_vel_x = out_rdata[W-1:0];
    assign o_new_vel_y = out_rdata[2*W-1:W];
    assign o_new_vel_z = out_rdata[3*W-1:2*W];
    assign o_kill      = out_rdata[3*W];
endmodule
`default_nettype wire

>>> sv/piv_checker.sv
// Port-level checker of the velocity unit and its bind.
`default_nettype none
`include "assert_macros.svh"
module piv_checker #(
    parameter int COORD_WIDTH = piv_pkg::COORD_WIDTH_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   push,
    input wire logic                   full,
    input wire logic                   empty,
    input wire logic                   pop,
    input wire logic [COORD_WIDTH-1:0] o_new_vel_x,
    input wire logic [COORD_WIDTH-1:0] o_new_vel_y,
    input wire logic [COORD_WIDTH-1:0] o_new_vel_z,
    input wire logic                   o_kill
);
    logic [3*COORD_WIDTH:0] res_bits;

    assign res_bits = {o_kill, o_new_vel_z, o_new_vel_y, o_new_vel_x};

    `PIV_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty)
    `PIV_ASSERT_NEXT(a_result_stable, i_clk, i_rst_n, !empty && !pop && !push, $stable(res_bits))
    `PIV_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, empty)
    `PIV_ASSERT_RST(a_reset_not_full, i_clk, !i_rst_n, !full)
endmodule

bind particle_implosion_velocity_unit piv_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_piv_checker (.*);
`default_nettype wire
